@@ sv/cfe_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the COBS frame encoder.
// Depends on nothing; every other file of the encoder but the RAM refers to it.
package cfe_pkg;

  localparam int BYTE_W      = 8;
  localparam int BLOCK_LIMIT = 254;
  localparam int OUT_LANES   = 8;
  localparam int LANE_IDX_W  = $clog2(OUT_LANES);
  localparam int LANE_CNT_W  = $clog2(OUT_LANES + 1);

  localparam logic [BYTE_W-1:0] DELIMITER = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CODE,
    ST_DATA,
    ST_AFTER,
    ST_DELIM
  } cfe_state_t;

  // One encoded byte on its way from the sequencer to the lane packer.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } byte_req_t;

endpackage

@@ sv/cfe_msg_if.sv @@
`timescale 1ns / 1ps
// Input channel of the encoder: one raw message byte per request.
// Depends on cfe_pkg.
interface cfe_msg_if;
  logic                       valid;
  logic                       ready;
  logic [cfe_pkg::BYTE_W-1:0] data_byte;
  logic                       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

@@ sv/cfe_enc_if.sv @@
`timescale 1ns / 1ps
// Output channel of the encoder: up to eight encoded bytes per request.
// Depends on cfe_pkg.
interface cfe_enc_if;
  logic                           valid;
  logic                           ready;
  logic [cfe_pkg::BYTE_W-1:0]     lane_0;
  logic [cfe_pkg::BYTE_W-1:0]     lane_1;
  logic [cfe_pkg::BYTE_W-1:0]     lane_2;
  logic [cfe_pkg::BYTE_W-1:0]     lane_3;
  logic [cfe_pkg::BYTE_W-1:0]     lane_4;
  logic [cfe_pkg::BYTE_W-1:0]     lane_5;
  logic [cfe_pkg::BYTE_W-1:0]     lane_6;
  logic [cfe_pkg::BYTE_W-1:0]     lane_7;
  logic [cfe_pkg::LANE_CNT_W-1:0] lane_count;
  logic                           run_last;

  modport source (output valid, output lane_0, output lane_1, output lane_2,
                  output lane_3, output lane_4, output lane_5, output lane_6,
                  output lane_7, output lane_count, output run_last, input ready);
  modport sink (input valid, input lane_0, input lane_1, input lane_2,
                input lane_3, input lane_4, input lane_5, input lane_6,
                input lane_7, input lane_count, input run_last, output ready);
endinterface

@@ sv/cfe_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module cfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/cfe_seq.sv @@
`timescale 1ns / 1ps
// Block sequencer: stores nonzero bytes in the block RAM and, when a block
// closes, streams its code byte and contents out one byte per ready cycle.
// Depends on cfe_pkg, cfe_msg_if and the block RAM ports.
module cfe_seq #(
  parameter int BLOCK_LIMIT = cfe_pkg::BLOCK_LIMIT,
  localparam int AW    = $clog2(BLOCK_LIMIT),
  localparam int CNT_W = $clog2(BLOCK_LIMIT + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  cfe_msg_if.sink                    msg,
  output logic                       we,
  output logic [AW-1:0]              waddr,
  output logic [cfe_pkg::BYTE_W-1:0] wdata,
  output logic                       re,
  output logic [AW-1:0]              raddr,
  input  logic [cfe_pkg::BYTE_W-1:0] rdata,
  output logic                       byte_valid,
  output cfe_pkg::byte_req_t         byte_req,
  input  logic                       byte_ready
);

  cfe_pkg::cfe_state_t       state, state_next;
  logic [CNT_W-1:0]          held, held_next;
  logic [CNT_W-1:0]          rd_idx, rd_idx_next;
  logic [cfe_pkg::BYTE_W-1:0] cur_byte, cur_byte_next;
  logic                      cur_last, cur_last_next;
  logic                      byte_done, byte_done_next;
  logic                      final_done, final_done_next;

  logic                      final_blk;
  logic [CNT_W:0]            code_wide;
  logic [CNT_W-1:0]          idx_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cfe_pkg::ST_IDLE;
      held       <= '0;
      byte_done  <= 1'b0;
      final_done <= 1'b0;
    end else begin
      state      <= state_next;
      held       <= held_next;
      byte_done  <= byte_done_next;
      final_done <= final_done_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx   <= rd_idx_next;
    cur_byte <= cur_byte_next;
    cur_last <= cur_last_next;
  end

  // A block is the final output of this request when no zero byte is still
  // pending behind it and no delimiter follows.
  assign final_blk = !cur_last && (byte_done || (cur_byte != '0));
  assign code_wide = {1'b0, held} + 1'b1;
  assign idx_inc   = rd_idx + 1'b1;

  always_comb begin
    state_next      = state;
    held_next       = held;
    rd_idx_next     = rd_idx;
    cur_byte_next   = cur_byte;
    cur_last_next   = cur_last;
    byte_done_next  = byte_done;
    final_done_next = final_done;
    we              = 1'b0;
    waddr           = held[AW-1:0];
    wdata           = cur_byte;
    re              = 1'b0;
    raddr           = '0;
    msg.ready       = 1'b0;
    byte_valid      = 1'b0;
    byte_req.data   = '0;
    byte_req.last   = 1'b0;

    case (state)
      cfe_pkg::ST_IDLE: begin
        msg.ready = 1'b1;
        if (msg.valid) begin
          cur_byte_next   = msg.data_byte;
          cur_last_next   = msg.end_of_message;
          final_done_next = 1'b0;
          if (held == CNT_W'(BLOCK_LIMIT)) begin
            // Full store: flush it before the new byte is looked at.
            byte_done_next = 1'b0;
            state_next     = cfe_pkg::ST_CODE;
          end else if (msg.data_byte == '0) begin
            byte_done_next = 1'b1;
            state_next     = cfe_pkg::ST_CODE;
          end else begin
            we             = 1'b1;
            waddr          = held[AW-1:0];
            wdata          = msg.data_byte;
            held_next      = held + 1'b1;
            byte_done_next = 1'b1;
            if (msg.end_of_message) begin
              final_done_next = 1'b1;
              state_next      = cfe_pkg::ST_CODE;
            end
          end
        end
      end
      cfe_pkg::ST_CODE: begin
        byte_valid    = 1'b1;
        byte_req.data = code_wide[cfe_pkg::BYTE_W-1:0];
        byte_req.last = final_blk && (held == '0);
        if (byte_ready) begin
          if (held == '0) begin
            state_next = cfe_pkg::ST_AFTER;
          end else begin
            re          = 1'b1;
            raddr       = '0;
            rd_idx_next = '0;
            state_next  = cfe_pkg::ST_DATA;
          end
        end
      end
      cfe_pkg::ST_DATA: begin
        byte_valid    = 1'b1;
        byte_req.data = rdata;
        byte_req.last = final_blk && (idx_inc == held);
        if (byte_ready) begin
          if (idx_inc == held) begin
            held_next  = '0;
            state_next = cfe_pkg::ST_AFTER;
          end else begin
            re          = 1'b1;
            raddr       = idx_inc[AW-1:0];
            rd_idx_next = idx_inc;
          end
        end
      end
      cfe_pkg::ST_AFTER: begin
        if (!byte_done) begin
          // The byte that waited behind a full-store flush, against an empty store.
          byte_done_next = 1'b1;
          if (cur_byte == '0) begin
            state_next = cfe_pkg::ST_CODE;
          end else begin
            we        = 1'b1;
            waddr     = '0;
            wdata     = cur_byte;
            held_next = CNT_W'(1);
            if (cur_last) begin
              final_done_next = 1'b1;
              state_next      = cfe_pkg::ST_CODE;
            end else begin
              state_next = cfe_pkg::ST_IDLE;
            end
          end
        end else if (cur_last && !final_done) begin
          final_done_next = 1'b1;
          state_next      = cfe_pkg::ST_CODE;
        end else if (cur_last) begin
          state_next = cfe_pkg::ST_DELIM;
        end else begin
          state_next = cfe_pkg::ST_IDLE;
        end
      end
      cfe_pkg::ST_DELIM: begin
        byte_valid    = 1'b1;
        byte_req.data = cfe_pkg::DELIMITER;
        byte_req.last = 1'b1;
        if (byte_ready) begin
          state_next = cfe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cfe_pkg::ST_IDLE;
      end
    endcase
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(BLOCK_LIMIT))
    else $error("held count beyond the block limit");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == cfe_pkg::ST_IDLE || state == cfe_pkg::ST_AFTER))
    else $error("block RAM written while a block is being read out");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == cfe_pkg::ST_DATA) |-> (rd_idx < held))
    else $error("read index at or beyond the held count");

  a_data_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    (state == cfe_pkg::ST_DATA && $past(state) == cfe_pkg::ST_CODE) |-> (rd_idx == '0))
    else $error("block read-out did not start at the first entry");

endmodule

@@ sv/cfe_pack.sv @@
`timescale 1ns / 1ps
// Lane packer: gathers the encoded byte stream into groups of up to eight
// lanes and holds each group in an output register until it is taken.
// Depends on cfe_pkg and cfe_enc_if.
module cfe_pack (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  input  cfe_pkg::byte_req_t byte_req,
  output logic               byte_ready,
  cfe_enc_if.source          enc
);

  logic [cfe_pkg::OUT_LANES-1:0][cfe_pkg::BYTE_W-1:0] acc;
  logic [cfe_pkg::LANE_IDX_W-1:0]                     acc_cnt;
  logic [cfe_pkg::OUT_LANES-1:0][cfe_pkg::BYTE_W-1:0] out_lanes, lanes_next;
  logic [cfe_pkg::LANE_CNT_W-1:0]                     out_cnt;
  logic                                               out_last;
  logic                                               out_valid;
  logic                                               completes;
  logic                                               byte_fire;

  // A group closes on its eighth byte or on the last byte of a request.
  assign completes  = byte_req.last || (acc_cnt == cfe_pkg::LANE_IDX_W'(cfe_pkg::OUT_LANES - 1));
  assign byte_ready = !completes || !out_valid || enc.ready;
  assign byte_fire  = byte_valid && byte_ready;

  always_comb begin
    for (int j = 0; j < cfe_pkg::OUT_LANES; j++) begin
      if (cfe_pkg::LANE_IDX_W'(j) < acc_cnt) begin
        lanes_next[j] = acc[j];
      end else if (cfe_pkg::LANE_IDX_W'(j) == acc_cnt) begin
        lanes_next[j] = byte_req.data;
      end else begin
        lanes_next[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      acc_cnt   <= '0;
    end else begin
      if (out_valid && enc.ready) begin
        out_valid <= 1'b0;
      end
      if (byte_fire) begin
        if (completes) begin
          out_valid <= 1'b1;
          acc_cnt   <= '0;
        end else begin
          acc_cnt <= acc_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_fire) begin
      if (completes) begin
        out_lanes <= lanes_next;
        out_cnt   <= cfe_pkg::LANE_CNT_W'(acc_cnt) + 1'b1;
        out_last  <= byte_req.last;
      end else begin
        acc[acc_cnt] <= byte_req.data;
      end
    end
  end

  assign enc.valid      = out_valid;
  assign enc.lane_0     = out_lanes[0];
  assign enc.lane_1     = out_lanes[1];
  assign enc.lane_2     = out_lanes[2];
  assign enc.lane_3     = out_lanes[3];
  assign enc.lane_4     = out_lanes[4];
  assign enc.lane_5     = out_lanes[5];
  assign enc.lane_6     = out_lanes[6];
  assign enc.lane_7     = out_lanes[7];
  assign enc.lane_count = out_cnt;
  assign enc.run_last   = out_last;

endmodule

@@ sv/cobs_frame_encoder_core.sv @@
`timescale 1ns / 1ps
// COBS frame encoder, top level: block RAM, sequencer and lane packer.
// Depends on cfe_pkg, cfe_msg_if, cfe_enc_if, cfe_ram, cfe_seq and cfe_pack.
//
// Use: raw message bytes arrive on the msg channel, one per request, with
// end_of_message marking the last byte of a message. Encoded bytes leave on
// the enc channel, packed from lane_0 upward, up to eight per request, with
// lane_count giving the number of valid lanes (unused lanes read zero) and
// run_last marking the final output request caused by one input byte.
// A nonzero byte that closes nothing is stored and produces no output.
// A byte that closes a block (a zero, a full store or the end of a message)
// is accepted, then the sequencer sends the code byte and each held byte
// in turn, makes a block decision after each block, and at the end of a
// message sends the closing delimiter.
// The block RAM has a single read port, so the read-out runs at one byte a
// cycle while the receiver takes the output.
// Reset clears the held count and all control state; the RAM contents are
// not cleared, since only entries already written are ever read. When the
// receiver stalls, the packer holds its output register and the sequencer
// pauses on the pending byte; no new input is taken until the read-out ends.
module cobs_frame_encoder_core #(
  parameter int BLOCK_LIMIT = cfe_pkg::BLOCK_LIMIT
) (
  input  logic      clk,
  input  logic      rst,
  cfe_msg_if.sink   msg,
  cfe_enc_if.source enc
);

  localparam int AW = $clog2(BLOCK_LIMIT);

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [cfe_pkg::BYTE_W-1:0] wdata;
  logic                       re;
  logic [AW-1:0]              raddr;
  logic [cfe_pkg::BYTE_W-1:0] rdata;

  // Byte stream between the sequencer and the packer.
  logic                       byte_valid;
  cfe_pkg::byte_req_t         byte_req;
  logic                       byte_ready;

  // The block store holds the nonzero bytes of the current block.
  cfe_ram #(
    .WIDTH (cfe_pkg::BYTE_W),
    .DEPTH (BLOCK_LIMIT)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // The sequencer decides when a block closes and walks it out of the RAM.
  cfe_seq #(
    .BLOCK_LIMIT (BLOCK_LIMIT)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .msg        (msg),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .re         (re),
    .raddr      (raddr),
    .rdata      (rdata),
    .byte_valid (byte_valid),
    .byte_req   (byte_req),
    .byte_ready (byte_ready)
  );

  // The packer turns the byte stream into eight-lane output requests.
  cfe_pack u_pack (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_req   (byte_req),
    .byte_ready (byte_ready),
    .enc        (enc)
  );

endmodule

@@ verif/tb_cobs_frame_encoder_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the COBS frame encoder core: a queue-fed driver on the
// message channel, a monitor on the encoded channel, and a predictor of the encoding.
// Depends on cfe_pkg, cfe_msg_if, cfe_enc_if and cobs_frame_encoder_core.
module tb_cobs_frame_encoder_core;

  // Run control. The limit is many times the slowest correct run of this stimulus.
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 6;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_WAIT  = 24;
  localparam int MAX_REPORTS  = 10;

  // One raw byte request, with markers that steer the driver and the receiver.
  typedef struct {
    logic [cfe_pkg::BYTE_W-1:0] data;
    logic                       eom;
    bit                         drain_first; // wait until every encoded word has arrived
    bit                         start_hold;  // the receiver begins its long hold-off here
  } msg_req_t;

  // One encoded output request as the block should present it.
  typedef struct packed {
    logic [cfe_pkg::OUT_LANES-1:0][cfe_pkg::BYTE_W-1:0] lanes;
    logic [cfe_pkg::LANE_CNT_W-1:0]                     lane_count;
    logic                                               run_last;
  } enc_word_t;

  logic clk;
  logic rst;

  cfe_msg_if msg_ch ();
  cfe_enc_if enc_ch ();

  cobs_frame_encoder_core DUT (
    .clk (clk),
    .rst (rst),
    .msg (msg_ch),
    .enc (enc_ch)
  );

  // Raw bytes still to be offered, and encoded words still to be seen.
  msg_req_t  raw_byte_q[$];
  enc_word_t enc_word_q[$];

  // The predictor's own picture of the encoder: the held block and its fill.
  logic [cfe_pkg::BYTE_W-1:0] held_bytes [cfe_pkg::BLOCK_LIMIT];
  int                         held_fill = 0;
  logic [cfe_pkg::BYTE_W-1:0] coded_byte_q[$];

  int  total_items;
  int  n_accepted  = 0;
  int  n_predicted = 0;
  int  n_checked;
  int  n_mismatch  = 0;
  int  cycle_count;

  int  tx_gap;
  bit  tx_burst = 1'b0;
  int  rx_gap;
  bit  rx_burst = 1'b0;
  logic hold_go;
  logic rx_hold;
  logic hold_armed;
  int   hold_left;

  // 2 ns clock.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Reset is applied once at the start and then released; the channel inputs
  // are set to their idle levels by the driver and the monitor during reset.
  initial begin
    rst = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Closing a block emits the code byte (held count plus one) followed by the
  // held bytes, and empties the store.
  task automatic close_held_block();
    int n;
    n = (held_fill > cfe_pkg::BLOCK_LIMIT) ? cfe_pkg::BLOCK_LIMIT : held_fill;
    coded_byte_q.push_back(cfe_pkg::BYTE_W'((n + 1) & 8'hFF));
    for (int i = 0; i < n; i++) coded_byte_q.push_back(held_bytes[i]);
    held_fill = 0;
  endtask

  // Works out the encoded words that one accepted raw byte causes and queues
  // them in order. A plain nonzero byte into a store that is not full causes
  // nothing at all.
  task automatic cobs_encode_step(input logic [cfe_pkg::BYTE_W-1:0] data, input logic eom);
    enc_word_t w;
    int        cnt;
    coded_byte_q.delete();
    // A store that filled up on the previous byte goes out as a 0xFF block
    // before this byte is looked at.
    if (held_fill >= cfe_pkg::BLOCK_LIMIT) close_held_block();
    if (data == '0) begin
      close_held_block();
    end else begin
      held_bytes[held_fill] = data;
      held_fill++;
    end
    if (eom) begin
      close_held_block();
      coded_byte_q.push_back(cfe_pkg::DELIMITER);
    end
    // Pack the coded bytes from lane 0 upward, eight to a request; lanes past
    // the count are expected to read zero.
    while (coded_byte_q.size() != 0) begin
      w   = '0;
      cnt = 0;
      while (cnt < cfe_pkg::OUT_LANES && coded_byte_q.size() != 0) begin
        w.lanes[cnt] = coded_byte_q.pop_front();
        cnt++;
      end
      w.lane_count = cfe_pkg::LANE_CNT_W'(cnt);
      w.run_last   = (coded_byte_q.size() == 0);
      enc_word_q.push_back(w);
      n_predicted++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the queued raw bytes on the message channel. Each request
  // is followed by a random gap, except during bursts when requests follow
  // back to back. Valid is written once per edge, so a request that follows
  // an accepted one keeps valid high without a glitch.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : msg_driver
    int  g;
    bit  busy;
    if (rst) begin
      msg_ch.valid          <= 1'b0;
      msg_ch.data_byte      <= '0;
      msg_ch.end_of_message <= 1'b0;
      tx_gap                <= 0;
      hold_go               <= 1'b0;
    end else begin
      g    = tx_gap;
      busy = msg_ch.valid;
      if (msg_ch.valid && msg_ch.ready) begin
        // The request is taken at this edge: predict what it causes.
        cobs_encode_step(msg_ch.data_byte, msg_ch.end_of_message);
        n_accepted++;
        busy = 1'b0;
        g    = tx_burst ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
      end
      if (!busy) begin
        if (g != 0) begin
          g = g - 1;
          msg_ch.valid <= 1'b0;
        end else if (raw_byte_q.size() != 0 &&
                     !(raw_byte_q[0].drain_first && n_predicted != n_checked)) begin
          // A request marked to drain first is held back until every
          // encoded word predicted so far has been seen by the monitor.
          msg_ch.valid          <= 1'b1;
          msg_ch.data_byte      <= raw_byte_q[0].data;
          msg_ch.end_of_message <= raw_byte_q[0].eom;
          if (raw_byte_q[0].start_hold) hold_go <= 1'b1;
          void'(raw_byte_q.pop_front());
        end else begin
          msg_ch.valid <= 1'b0;
        end
      end
      tx_gap <= g;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver hold-off: once the flagged request is offered, ready is kept low
  // for a long stretch while the driver carries on, so the block backs up and
  // stops taking raw bytes.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : rx_hold_off
    if (rst) begin
      hold_left  <= 0;
      rx_hold    <= 1'b0;
      hold_armed <= 1'b1;
    end else if (hold_armed && hold_go) begin
      hold_left  <= HOLD_CYCLES;
      rx_hold    <= 1'b1;
      hold_armed <= 1'b0;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
    end else begin
      hold_left <= 0;
      rx_hold   <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes encoded requests, compares every field with the oldest
  // prediction, and then stalls for a random gap (none in bursts).
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : enc_monitor
    enc_word_t got;
    enc_word_t want;
    bit        bad;
    int        g;
    if (rst) begin
      enc_ch.ready <= 1'b0;
      rx_gap       <= 0;
      n_checked    <= 0;
    end else begin
      g = rx_gap;
      if (enc_ch.valid && enc_ch.ready) begin
        got.lanes      = {enc_ch.lane_7, enc_ch.lane_6, enc_ch.lane_5, enc_ch.lane_4,
                          enc_ch.lane_3, enc_ch.lane_2, enc_ch.lane_1, enc_ch.lane_0};
        got.lane_count = enc_ch.lane_count;
        got.run_last   = enc_ch.run_last;
        if (enc_word_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS)
            $display("[%0d] unexpected encoded request: lanes(7..0) %h count %0d last %0b",
                     cycle_count, got.lanes, got.lane_count, got.run_last);
        end else begin
          want = enc_word_q.pop_front();
          bad  = 1'b0;
          for (int j = 0; j < cfe_pkg::OUT_LANES; j++)
            if (got.lanes[j] !== want.lanes[j]) bad = 1'b1;
          if (got.lane_count !== want.lane_count) bad = 1'b1;
          if (got.run_last !== want.run_last) bad = 1'b1;
          if (bad) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS) begin
              $display("[%0d] encoded mismatch", cycle_count);
              $display("  expected lanes(7..0) %h count %0d last %0b",
                       want.lanes, want.lane_count, want.run_last);
              $display("  got      lanes(7..0) %h count %0d last %0b",
                       got.lanes, got.lane_count, got.run_last);
            end
          end
          n_checked <= n_checked + 1;
        end
        g = rx_burst ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      end
      if (g != 0) begin
        enc_ch.ready <= 1'b0;
        rx_gap       <= g - 1;
      end else begin
        enc_ch.ready <= !rx_hold;
        rx_gap       <= 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  function automatic void queue_raw_byte(input logic [cfe_pkg::BYTE_W-1:0] data,
                                         input logic eom,
                                         input bit drain_first = 1'b0,
                                         input bit start_hold = 1'b0);
    msg_req_t r;
    r.data        = data;
    r.eom         = eom;
    r.drain_first = drain_first;
    r.start_hold  = start_hold;
    raw_byte_q.push_back(r);
  endfunction

  initial begin : stimulus
    int                         n_random;
    int                         len;
    logic [cfe_pkg::BYTE_W-1:0] b;

    // Directed part. A lone zero that ends the message gives two empty blocks.
    queue_raw_byte(8'h00, 1'b1);
    // A single top-value byte as a whole message.
    queue_raw_byte(8'hFF, 1'b1);
    // Bytes that are only stored, then a zero that closes them, then a
    // one-byte message.
    queue_raw_byte(8'h01, 1'b0);
    queue_raw_byte(8'h80, 1'b0);
    queue_raw_byte(8'h7F, 1'b0);
    queue_raw_byte(8'h00, 1'b0);
    queue_raw_byte(8'hFE, 1'b1);
    // A run of zeros.
    queue_raw_byte(8'h00, 1'b0);
    queue_raw_byte(8'h00, 1'b0);
    queue_raw_byte(8'h00, 1'b1);
    // A block long enough to spill into a second output request.
    queue_raw_byte(8'h55, 1'b0);
    queue_raw_byte(8'hAA, 1'b0);
    for (int i = 1; i <= 7; i++) queue_raw_byte(cfe_pkg::BYTE_W'(i), i == 7);
    // Zero in the middle of a message, then a nonzero last byte.
    queue_raw_byte(8'h33, 1'b0);
    queue_raw_byte(8'h00, 1'b0);
    queue_raw_byte(8'h0F, 1'b1);

    // Full block. The sender first waits for the directed part to drain.
    // The zero that ends the message meets a full store, so 0xFF and its 254
    // bytes go out, the zero adds code 0x01 and the message end adds another
    // 0x01 and the delimiter. The receiver's long hold-off starts with that
    // zero while the sender goes on offering the messages that follow.
    for (int i = 0; i < cfe_pkg::BLOCK_LIMIT; i++)
      queue_raw_byte(cfe_pkg::BYTE_W'($urandom_range(1, 255)), 1'b0, i == 0);
    queue_raw_byte(8'h00, 1'b1, 1'b0, 1'b1);

    // A few short random messages with a fair share of zeros.
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      len = $urandom_range(1, 5);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 3))
          0:       b = 8'h00;
          1:       b = cfe_pkg::BYTE_W'($urandom_range(0, 255));
          default: b = cfe_pkg::BYTE_W'($urandom_range(1, 255));
        endcase
        queue_raw_byte(b, k == len - 1);
        n_random++;
      end
    end
    total_items = raw_byte_q.size();

    // Wait for every request to be taken and every prediction to be met,
    // then give the block time to show anything it should not produce.
    @(negedge rst);
    while (n_accepted != total_items || n_predicted != n_checked) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);

    if (enc_word_q.size() != 0)
      $display("%0d predicted encoded requests never arrived", enc_word_q.size());
    if (n_mismatch == 0 && enc_word_q.size() == 0) begin
      $display("** cobs_frame_encoder_core: PASSED **");
    end else begin
      $display("** cobs_frame_encoder_core: FAILED **");
    end
    $finish;
  end

  // Watchdog: a stuck handshake ends the run as a failure.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** cobs_frame_encoder_core: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
sv/cfe_pkg.sv
sv/cfe_msg_if.sv
sv/cfe_enc_if.sv
sv/cfe_ram.sv
sv/cfe_seq.sv
sv/cfe_pack.sv
sv/cobs_frame_encoder_core.sv
verif/tb_cobs_frame_encoder_core.sv
